// ===== sv/sofp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofp_pkg
// Shared types and codes of the start-of-frame / length / XOR frame parser.
// ----------------------------------------------------------------------------
package sofp_pkg;

    // Parser stage
    typedef enum logic [1:0] {
        STAGE_HUNT = 2'd0,
        STAGE_LEN  = 2'd1,
        STAGE_DATA = 2'd2,
        STAGE_FCS  = 2'd3
    } stage_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_START   = 3'd1,
        ST_REJECT  = 3'd2,
        ST_STORED  = 3'd3,
        ST_GOOD    = 3'd4,
        ST_BADFCS  = 3'd5,
        ST_READ    = 3'd6,
        ST_RESYNC  = 3'd7
    } status_t;

    // Command codes
    localparam logic [1:0] CMD_RX     = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_RESYNC = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_BYTE   = 2'd0;
    localparam logic [1:0] CFG_MAX_PAYLOAD  = 2'd1;
    localparam logic [1:0] CFG_HEADER_BYTES = 2'd2;

    // Configuration reset values
    localparam logic [7:0] START_BYTE_RST   = 8'd254;
    localparam logic [7:0] MAX_PAYLOAD_RST  = 8'd250;
    localparam logic [1:0] HEADER_BYTES_RST = 2'd3;

    // Parser result handed to the output pipeline
    typedef struct packed {
        status_t    status;
        logic [7:0] frame_length;
        logic [7:0] byte_index;
        logic       rd_ok;
    } result_t;

endpackage

// ===== sv/sofp_frame_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofp_frame_mem
// Frame byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sofp_frame_mem #(
    parameter int FRAME_DEPTH = 256,
    parameter int AW          = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [FRAME_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sofp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofp_parser
// Configuration registers, frame parse state machine and frame store access.
// ----------------------------------------------------------------------------
module sofp_parser #(
    parameter int FRAME_DEPTH = 256,
    parameter int AW          = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [7:0]        cfg_wr_data,
    input  logic              accept,
    input  logic [1:0]        command,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        read_index,
    output sofp_pkg::result_t res,
    output logic              mem_wr_en,
    output logic [AW-1:0]     mem_wr_addr,
    output logic [7:0]        mem_wr_data,
    output logic              mem_rd_en,
    output logic [AW-1:0]     mem_rd_addr
);

    localparam logic [8:0] LEN_CAP   = 9'(FRAME_DEPTH - 1);
    localparam logic [8:0] DEPTH_LIM = 9'(FRAME_DEPTH);

    logic [7:0] start_byte_reg;
    logic [7:0] max_payload_reg;
    logic [1:0] header_bytes_reg;

    sofp_pkg::stage_t stage_reg, stage_next;
    logic [7:0] fill_reg, fill_next;
    logic [7:0] exp_reg, exp_next;
    logic [7:0] xor_reg, xor_next;

    logic [8:0] len_sum;
    logic [7:0] len_total;
    logic [7:0] fill_inc;
    logic       pos_ok;
    logic       rd_in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg   <= sofp_pkg::START_BYTE_RST;
            max_payload_reg  <= sofp_pkg::MAX_PAYLOAD_RST;
            header_bytes_reg <= sofp_pkg::HEADER_BYTES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                sofp_pkg::CFG_START_BYTE:   start_byte_reg   <= cfg_wr_data;
                sofp_pkg::CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_wr_data;
                sofp_pkg::CFG_HEADER_BYTES: header_bytes_reg <= cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= sofp_pkg::STAGE_HUNT;
            fill_reg  <= '0;
            exp_reg   <= '0;
            xor_reg   <= '0;
        end else if (accept) begin
            stage_reg <= stage_next;
            fill_reg  <= fill_next;
            exp_reg   <= exp_next;
            xor_reg   <= xor_next;
        end
    end

    // Stored length: length byte plus header, saturated to the buffer depth minus one, at least one
    always_comb begin
        len_sum = {1'b0, rx_byte} + {7'd0, header_bytes_reg};
        if (len_sum > LEN_CAP) begin
            len_sum = LEN_CAP;
        end
        if (len_sum == 9'd0) begin
            len_sum = 9'd1;
        end
        len_total = len_sum[7:0];
    end

    assign fill_inc    = fill_reg + 8'd1;
    assign pos_ok      = {1'b0, fill_reg} < DEPTH_LIM;
    assign rd_in_range = {1'b0, read_index} < DEPTH_LIM;

    always_comb begin
        stage_next       = stage_reg;
        fill_next        = fill_reg;
        exp_next         = exp_reg;
        xor_next         = xor_reg;
        res.status       = sofp_pkg::ST_IGNORED;
        res.byte_index   = '0;
        res.rd_ok        = 1'b0;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = fill_reg[AW-1:0];
        mem_wr_data      = rx_byte;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = read_index[AW-1:0];

        unique case (command)
            sofp_pkg::CMD_RX: begin
                unique case (stage_reg)
                    sofp_pkg::STAGE_HUNT: begin
                        if (rx_byte == start_byte_reg) begin
                            stage_next = sofp_pkg::STAGE_LEN;
                            res.status = sofp_pkg::ST_START;
                        end
                    end
                    sofp_pkg::STAGE_LEN: begin
                        if (rx_byte > max_payload_reg) begin
                            stage_next = sofp_pkg::STAGE_HUNT;
                            res.status = sofp_pkg::ST_REJECT;
                        end else begin
                            // Length byte opens the frame at position zero
                            exp_next    = len_total;
                            xor_next    = rx_byte;
                            fill_next   = 8'd1;
                            mem_wr_en   = accept;
                            mem_wr_addr = '0;
                            res.status  = sofp_pkg::ST_STORED;
                            stage_next  = (len_total <= 8'd1) ? sofp_pkg::STAGE_FCS
                                                              : sofp_pkg::STAGE_DATA;
                        end
                    end
                    sofp_pkg::STAGE_DATA: begin
                        xor_next       = xor_reg ^ rx_byte;
                        fill_next      = fill_inc;
                        mem_wr_en      = accept && pos_ok;
                        res.status     = sofp_pkg::ST_STORED;
                        res.byte_index = fill_reg;
                        if (fill_inc >= exp_reg) begin
                            stage_next = sofp_pkg::STAGE_FCS;
                        end
                    end
                    sofp_pkg::STAGE_FCS: begin
                        stage_next = sofp_pkg::STAGE_HUNT;
                        res.status = (xor_reg == rx_byte) ? sofp_pkg::ST_GOOD
                                                          : sofp_pkg::ST_BADFCS;
                    end
                    default: ;
                endcase
            end
            sofp_pkg::CMD_READ: begin
                res.status = sofp_pkg::ST_READ;
                res.rd_ok  = rd_in_range;
                mem_rd_en  = accept && rd_in_range;
            end
            sofp_pkg::CMD_RESYNC: begin
                stage_next = sofp_pkg::STAGE_HUNT;
                fill_next  = '0;
                res.status = sofp_pkg::ST_RESYNC;
            end
            default: ;
        endcase

        res.frame_length = exp_next;
    end

    // A frame in progress never has more bytes than its length
    a_fill_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_reg == sofp_pkg::STAGE_DATA |-> fill_reg < exp_reg)
        else $error("fill count reached frame length while receiving data");

    a_write_only_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> accept && res.status == sofp_pkg::ST_STORED)
        else $error("frame store written without a stored byte");

    a_stored_has_len: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.status == sofp_pkg::ST_STORED |-> res.frame_length != 8'd0)
        else $error("byte stored with zero frame length");

endmodule

// ===== sv/sofp_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofp_out_stage
// Read-latency stage and output register with backpressure.
// ----------------------------------------------------------------------------
module sofp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sofp_pkg::result_t res,
    input  logic [7:0]        mem_rd_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_status,
    output logic [7:0]        out_frame_length,
    output logic [7:0]        out_byte_index,
    output logic [7:0]        out_read_data
);

    logic              p1_valid_reg;
    sofp_pkg::result_t p1_res_reg;
    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic [7:0]        frame_length_reg;
    logic [7:0]        byte_index_reg;
    logic [7:0]        read_data_reg;
    logic              out_load;
    logic              p1_move;
    logic              accept;

    assign out_load = !out_valid_reg || out_ready;
    assign p1_move  = p1_valid_reg && out_load;
    assign in_ready = !p1_valid_reg || out_load;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_move) begin
                p1_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg <= res;
        end
        if (p1_move) begin
            status_reg       <= p1_res_reg.status;
            frame_length_reg <= p1_res_reg.frame_length;
            byte_index_reg   <= p1_res_reg.byte_index;
            read_data_reg    <= p1_res_reg.rd_ok ? mem_rd_data : 8'd0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = status_reg;
    assign out_frame_length = frame_length_reg;
    assign out_byte_index   = byte_index_reg;
    assign out_read_data    = read_data_reg;

    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && !out_load |=> p1_valid_reg && $stable(p1_res_reg))
        else $error("pending transaction lost while output stalled");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken while both stages are full");

    a_p1_feeds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_move |=> out_valid_reg)
        else $error("transaction moved out of read stage but output empty");

endmodule

// ===== sv/sof_length_xor_frame_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_length_xor_frame_parser_top
// Start-of-frame / length / XOR checksum parser for a received UART byte
// stream, with a frame buffer that can be read back.
//
//   Channel | Direction | Payload
//   --------+-----------+-----------------------------------------------
//   s_      | in        | tuser: command; tdata: rx_byte, read_index
//   m_      | out       | tuser: status; tdata: frame_length, byte_index,
//           |           |        read_data
//   cfg_    | in        | register index, write data (no read-back)
//
// One transaction per cycle while the output is not stalled; a result is held
// in the frame buffer read register and then in the output register.
// Reset is synchronous on aresetn; the frame buffer contents are not cleared.
// s_tready drops only while both the read stage and the output register hold
// a transaction and m_tready is low.
// ----------------------------------------------------------------------------
module sof_length_xor_frame_parser_top #(
    parameter int FRAME_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] read_index
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] frame_length, [15:8] byte_index, [23:16] read_data
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    sofp_pkg::result_t res;
    logic              accept;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [7:0]        mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [7:0]        mem_rd_data;
    logic [7:0]        frame_length;
    logic [7:0]        byte_index;
    logic [7:0]        read_data;

    assign accept = s_tvalid && s_tready;

    sofp_parser #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .AW          (AW)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .command     (s_tuser),
        .rx_byte     (s_tdata[7:0]),
        .read_index  (s_tdata[15:8]),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr)
    );

    sofp_frame_mem #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .AW          (AW)
    ) u_frame_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    sofp_out_stage u_out_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .res              (res),
        .mem_rd_data      (mem_rd_data),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_status       (m_tuser),
        .out_frame_length (frame_length),
        .out_byte_index   (byte_index),
        .out_read_data    (read_data)
    );

    assign m_tdata = {read_data, byte_index, frame_length};

endmodule
